// ===== rtl/rss_pkg.sv =====
// Shared widths, types and state codes of the running stream statistics block.
package rss_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int COUNT_BITS    = 24;
  localparam int FRAC_BITS     = 8;
  localparam int SQUARE_BITS   = 2 * SAMPLE_BITS - 1;
  localparam int SUM_BITS      = SAMPLE_BITS + COUNT_BITS;
  localparam int SQSUM_BITS    = SQUARE_BITS + COUNT_BITS;
  localparam int MEAN_BITS     = SAMPLE_BITS + FRAC_BITS;
  localparam int VAR_BITS      = 2 * SAMPLE_BITS - 2 + FRAC_BITS + 1;
  localparam int M2_BITS       = 2 * MEAN_BITS - FRAC_BITS;
  localparam int STD_BITS      = 20;
  localparam int DIVIDEND_BITS = SQSUM_BITS + FRAC_BITS;
  localparam int DIV_CNT_BITS  = $clog2(DIVIDEND_BITS + 1);
  localparam int RAD_BITS      = 2 * ((VAR_BITS + FRAC_BITS + 1) / 2);
  localparam int ROOT_BITS     = RAD_BITS / 2;
  localparam int ROOT_CNT_BITS = $clog2(ROOT_BITS + 1);
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_BITS     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_BITS     = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [STD_BITS-1:0]   STD_MAX   = '1;

  // Totals of one finished set, handed from front to back
  typedef struct packed {
    logic [COUNT_BITS-1:0]      count;
    logic signed [SUM_BITS-1:0] sum;
    logic [SQSUM_BITS-1:0]      square_sum;
    sample_t                    min_val;
    sample_t                    max_val;
    logic                       overflow;
  } set_totals_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MEAN,
    BK_SQUARE,
    BK_PRODUCT,
    BK_VARIANCE,
    BK_ROOT,
    BK_DONE
  } back_state_t;

endpackage

// ===== rtl/running_stream_statistics.sv =====
// Top level of the running stream statistics block.
//
// Input channel: sample and last are taken when push is high and full is low.
// Samples are accepted one per cycle while full is low. Each sample passes a square stage and an
// accumulate stage, which keeps count, sum, sum of squares, minimum and maximum.
// A sample with last set closes the set; its totals go into a two-entry queue.
// Result channel: while empty is low the result ports hold the oldest result;
// pop with empty low takes it.
// From the last sample of a set to its result, with an idle back end, the totals pass
// the input stage and the queue, two passes of a bit-serial divider (mean, then mean
// square), a multiply and a subtract step, a bit-serial square root of 24 root bits
// and the load of the result register.
// The divider and root unit handle one set at a time, so sets that come in faster than
// the back end finishes them fill the queue, and full then holds the input
// while a last sample waits. A result not taken holds the back end in its final
// state, which in turn holds the queue and the input.
// Reset is synchronous: it clears the totals (minimum to the largest sample, maximum
// to the most negative), empties the queue and drops any waiting result.
module running_stream_statistics import rss_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  output logic                        full,
  input  sample_t                     sample,
  input  logic                        last,
  output logic                        empty,
  input  logic                        pop,
  output logic [COUNT_BITS-1:0]       sample_count,
  output sample_t                     minimum,
  output sample_t                     maximum,
  output logic signed [MEAN_BITS-1:0] mean_value,
  output logic [VAR_BITS-1:0]         variance_value,
  output logic [STD_BITS-1:0]         std_deviation,
  output logic                        count_overflow
);

  logic        totals_valid;
  set_totals_t totals;
  logic        queue_full;
  logic        head_valid;
  set_totals_t head;
  logic        head_pop;

  rss_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .sample       (sample),
    .last         (last),
    .queue_full   (queue_full),
    .totals_valid (totals_valid),
    .totals       (totals)
  );

  rss_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (totals_valid),
    .wr_data  (totals),
    .full     (queue_full),
    .rd_valid (head_valid),
    .rd_data  (head),
    .rd_en    (head_pop)
  );

  rss_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head           (head),
    .head_pop       (head_pop),
    .empty          (empty),
    .pop            (pop),
    .sample_count   (sample_count),
    .minimum        (minimum),
    .maximum        (maximum),
    .mean_value     (mean_value),
    .variance_value (variance_value),
    .std_deviation  (std_deviation),
    .count_overflow (count_overflow)
  );

endmodule

// ===== rtl/rss_front.sv =====
// Front end: takes samples, squares them and keeps the running set totals.
module rss_front import rss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  sample_t     sample,
  input  logic        last,
  input  logic        queue_full,
  output logic        totals_valid,
  output set_totals_t totals
);

  logic                         a_valid;
  sample_t                      a_sample;
  logic                         a_last;
  logic [SQUARE_BITS-1:0]       a_square;

  logic [COUNT_BITS-1:0]        count_acc;
  logic signed [SUM_BITS-1:0]   sum_acc;
  logic [SQSUM_BITS-1:0]        square_sum_acc;
  sample_t                      min_seen;
  sample_t                      max_seen;
  logic                         overflow_seen;

  logic [SAMPLE_BITS-1:0]       sample_raw;
  logic [SAMPLE_BITS-1:0]       sample_mag;
  logic [2*SAMPLE_BITS-1:0]     square_full;
  logic                         a_stall;
  logic                         a_advance;
  logic                         accept;
  logic                         counting;

  // Magnitude and square of the incoming sample
  assign sample_raw  = sample;
  assign sample_mag  = sample_raw[SAMPLE_BITS-1] ? (~sample_raw + 1'b1) : sample_raw;
  assign square_full = sample_mag * sample_mag;

  // Hold a last sample while the queue has no room
  assign a_stall   = a_last && queue_full;
  assign a_advance = a_valid && !a_stall;
  assign full      = a_valid && a_stall;
  assign accept    = push && !full;

  assign counting = (count_acc != COUNT_MAX);

  // Updated totals, including the sample in the accumulate stage
  always_comb begin
    totals.min_val    = (a_sample < min_seen) ? a_sample : min_seen;
    totals.max_val    = (a_sample > max_seen) ? a_sample : max_seen;
    totals.count      = counting ? count_acc + 1'b1 : count_acc;
    totals.sum        = counting ? sum_acc + SUM_BITS'(a_sample) : sum_acc;
    totals.square_sum = counting ? square_sum_acc + SQSUM_BITS'(a_square) : square_sum_acc;
    totals.overflow   = overflow_seen || !counting;
  end

  assign totals_valid = a_advance && a_last;

  // Input stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (a_advance) begin
      a_valid <= 1'b0;
    end
  end

  // Input stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      a_sample <= sample;
      a_last   <= last;
      a_square <= square_full[SQUARE_BITS-1:0];
    end
  end

  // Accumulate, or clear after the last sample of a set
  always_ff @(posedge clk) begin
    if (rst || (a_advance && a_last)) begin
      count_acc      <= '0;
      sum_acc        <= '0;
      square_sum_acc <= '0;
      min_seen       <= SAMPLE_MAX;
      max_seen       <= SAMPLE_MIN;
      overflow_seen  <= 1'b0;
    end else if (a_advance) begin
      count_acc      <= totals.count;
      sum_acc        <= totals.sum;
      square_sum_acc <= totals.square_sum;
      min_seen       <= totals.min_val;
      max_seen       <= totals.max_val;
      overflow_seen  <= totals.overflow;
    end
  end

  a_set_cleared: assert property (@(posedge clk) disable iff (rst)
    (a_advance && a_last) |=> (count_acc == '0 && overflow_seen == 1'b0))
    else $error("set totals not cleared after last sample");

  a_overflow_saturated: assert property (@(posedge clk) disable iff (rst)
    overflow_seen |-> (count_acc == COUNT_MAX))
    else $error("overflow flagged with count below its maximum");

endmodule

// ===== rtl/rss_queue.sv =====
// Short queue of finished set totals between front and back.
module rss_queue import rss_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  set_totals_t wr_data,
  output logic        full,
  output logic        rd_valid,
  output set_totals_t rd_data,
  input  logic        rd_en
);

  set_totals_t            entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr;
  logic [QPTR_BITS-1:0]   rd_ptr;
  logic [QCNT_BITS-1:0]   fill;

  assign full     = (fill == QCNT_BITS'(QUEUE_DEPTH));
  assign rd_valid = (fill != '0);
  assign rd_data  = entries[rd_ptr];

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        fill <= fill + 1'b1;
      end else if (rd_en && !wr_en) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Store written entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  a_no_write_when_full: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full)
    else $error("queue written while full");

  a_no_read_when_empty: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> rd_valid)
    else $error("queue read while empty");

endmodule

// ===== rtl/rss_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle.
module rss_divider import rss_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [DIVIDEND_BITS-1:0] dividend,
  input  logic [COUNT_BITS-1:0]    divisor,
  output logic                     done,
  output logic [VAR_BITS-1:0]      quotient
);

  logic                     busy;
  logic [DIV_CNT_BITS-1:0]  cnt;
  logic [DIVIDEND_BITS-1:0] dvd;
  logic [COUNT_BITS-1:0]    dvs;
  logic [COUNT_BITS-1:0]    rem;
  logic [COUNT_BITS:0]      partial;
  logic [COUNT_BITS:0]      diff;
  logic                     fits;

  // One trial subtraction
  assign partial = {rem, dvd[DIVIDEND_BITS-1]};
  assign diff    = partial - {1'b0, dvs};
  assign fits    = (partial >= {1'b0, dvs});

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_BITS'(DIVIDEND_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift dividend, remainder and quotient
  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= {dvd[DIVIDEND_BITS-2:0], 1'b0};
      rem      <= fits ? diff[COUNT_BITS-1:0] : partial[COUNT_BITS-1:0];
      quotient <= {quotient[VAR_BITS-2:0], fits};
    end
  end

endmodule

// ===== rtl/rss_isqrt.sv =====
// Iterative integer square root, one root bit per cycle.
module rss_isqrt import rss_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [RAD_BITS-1:0]  radicand,
  output logic                 done,
  output logic [ROOT_BITS-1:0] root
);

  logic                     busy;
  logic [ROOT_CNT_BITS-1:0] cnt;
  logic [RAD_BITS-1:0]      rad;
  logic [ROOT_BITS+1:0]     rem;
  logic [ROOT_BITS+3:0]     partial;
  logic [ROOT_BITS+3:0]     trial;
  logic [ROOT_BITS+3:0]     diff;
  logic                     fits;

  // Trial subtraction of 4*root+1
  assign partial = {rem, rad[RAD_BITS-1 -: 2]};
  assign trial   = (ROOT_BITS+4)'({root, 2'b01});
  assign diff    = partial - trial;
  assign fits    = (partial >= trial);

  // Sequence the iterations
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= ROOT_CNT_BITS'(ROOT_BITS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == ROOT_CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift in two radicand bits, produce one root bit
  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[RAD_BITS-3:0], 2'b00};
      rem  <= fits ? diff[ROOT_BITS+1:0] : partial[ROOT_BITS+1:0];
      root <= {root[ROOT_BITS-2:0], fits};
    end
  end

endmodule

// ===== rtl/rss_back.sv =====
// Back end: turns set totals into mean, variance and deviation, holds the result.
module rss_back import rss_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     head_valid,
  input  set_totals_t              head,
  output logic                     head_pop,
  output logic                     empty,
  input  logic                     pop,
  output logic [COUNT_BITS-1:0]    sample_count,
  output sample_t                  minimum,
  output sample_t                  maximum,
  output logic signed [MEAN_BITS-1:0] mean_value,
  output logic [VAR_BITS-1:0]      variance_value,
  output logic [STD_BITS-1:0]      std_deviation,
  output logic                     count_overflow
);

  back_state_t              state;
  back_state_t              state_next;

  set_totals_t              job;
  logic [MEAN_BITS-1:0]     mean_mag;
  logic [VAR_BITS-1:0]      square_quot;
  logic [M2_BITS-1:0]       mean_sq;
  logic [STD_BITS-1:0]      std_val;
  logic                     out_valid;

  logic                     div_start;
  logic [DIVIDEND_BITS-1:0] div_dividend;
  logic [COUNT_BITS-1:0]    div_divisor;
  logic                     div_done;
  logic [VAR_BITS-1:0]      div_quotient;

  logic                     root_start;
  logic [RAD_BITS-1:0]      root_radicand;
  logic                     root_done;
  logic [ROOT_BITS-1:0]     root_val;

  logic [SUM_BITS-1:0]      head_sum;
  logic [SUM_BITS-1:0]      head_sum_mag;
  logic [2*MEAN_BITS-1:0]   mean_product;
  logic [M2_BITS-1:0]       square_quot_ext;
  logic [VAR_BITS-1:0]      variance;
  logic                     load_out;

  // Magnitude of the queued sum
  assign head_sum     = head.sum;
  assign head_sum_mag = head_sum[SUM_BITS-1] ? (~head_sum + 1'b1) : head_sum;

  // Divider operands: mean first from the queue head, then the mean square
  assign div_dividend = (state == BK_IDLE) ?
                        DIVIDEND_BITS'({head_sum_mag, {FRAC_BITS{1'b0}}}) :
                        {job.square_sum, {FRAC_BITS{1'b0}}};
  assign div_divisor  = (state == BK_IDLE) ? head.count : job.count;

  // Variance, clamped at zero
  assign mean_product    = mean_mag * mean_mag;
  assign square_quot_ext = M2_BITS'(square_quot);
  assign variance        = (square_quot_ext > mean_sq) ?
                           VAR_BITS'(square_quot_ext - mean_sq) : '0;
  assign root_radicand   = RAD_BITS'({variance, {FRAC_BITS{1'b0}}});

  rss_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  rss_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (root_radicand),
    .done     (root_done),
    .root     (root_val)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and unit controls
  always_comb begin
    state_next = state;
    head_pop   = 1'b0;
    div_start  = 1'b0;
    root_start = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (head_valid) begin
          head_pop   = 1'b1;
          div_start  = 1'b1;
          state_next = BK_MEAN;
        end
      end
      BK_MEAN: begin
        if (div_done) begin
          div_start  = 1'b1;
          state_next = BK_SQUARE;
        end
      end
      BK_SQUARE: begin
        if (div_done) begin
          state_next = BK_PRODUCT;
        end
      end
      BK_PRODUCT: begin
        state_next = BK_VARIANCE;
      end
      BK_VARIANCE: begin
        root_start = 1'b1;
        state_next = BK_ROOT;
      end
      BK_ROOT: begin
        if (root_done) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid || pop) begin
          load_out   = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  // Capture intermediate values
  always_ff @(posedge clk) begin
    if (head_pop) begin
      job <= head;
    end
    if (state == BK_MEAN && div_done) begin
      mean_mag <= div_quotient[MEAN_BITS-1:0];
    end
    if (state == BK_SQUARE && div_done) begin
      square_quot <= div_quotient;
    end
    if (state == BK_PRODUCT) begin
      mean_sq <= mean_product[2*MEAN_BITS-1:FRAC_BITS];
    end
    if (root_done) begin
      std_val <= (|root_val[ROOT_BITS-1:STD_BITS]) ? STD_MAX : root_val[STD_BITS-1:0];
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (load_out) begin
      sample_count   <= job.count;
      minimum        <= job.min_val;
      maximum        <= job.max_val;
      mean_value     <= job.sum[SUM_BITS-1] ? (~mean_mag + 1'b1) : mean_mag;
      variance_value <= variance;
      std_deviation  <= std_val;
      count_overflow <= job.overflow;
    end
  end

  // Result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  assign empty = !out_valid;

  a_div_done_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == BK_MEAN || state == BK_SQUARE))
    else $error("divider finished outside a division state");

  a_zero_var_zero_std: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((variance_value == '0) == (std_deviation == '0)))
    else $error("deviation disagrees with variance being zero");

endmodule
